// File: design/vna_pkg.sv
// Shared constants, payload types and command/status structs for the vertex normal accumulator.
package vna_pkg;

  localparam int VERTEX_COUNT = 256;
  localparam int COORD_BITS   = 16;

  localparam int IDX_BITS  = 8;
  localparam int ADDR_W    = ($clog2(VERTEX_COUNT) < IDX_BITS) ? $clog2(VERTEX_COUNT) : IDX_BITS;
  localparam int MEM_DEPTH = (VERTEX_COUNT < (1 << IDX_BITS)) ? VERTEX_COUNT : (1 << IDX_BITS);
  localparam int COORD_W   = 16;
  localparam int CIN_BITS  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int SUM_W     = 42;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int NRM_W     = 2 * DIFF_W + 1;
  localparam int MAG_W     = 24;
  localparam int MUL_W     = MAG_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SQ_W      = 2 * MUL_W;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int FRAC_BITS = 14;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
  localparam int OUT_W     = 16;
  localparam int CNT_W     = 5;
  localparam logic [OUT_W-1:0] Q_ONE = OUT_W'(1 << FRAC_BITS);

  localparam logic [CNT_W-1:0] TRI_MUL_LAST = CNT_W'(6);
  localparam logic [CNT_W-1:0] SQ_LAST      = CNT_W'(3);
  localparam logic [CNT_W-1:0] SQRT_LAST    = CNT_W'(ROOT_W);
  localparam logic [CNT_W-1:0] DIV_LAST     = CNT_W'(QUO_W + 1);
  localparam logic [1:0]       CORNER_LAST  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_BITS-1:0]       index_a;
    logic [IDX_BITS-1:0]       index_b;
    logic [IDX_BITS-1:0]       index_c;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic                    zero_length;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       vtx_wr;
    logic       vtx_rd;
    logic [1:0] corner;
    logic       diff;
    logic       mul_en;
    logic       mul_sq;
    logic [2:0] mul_step;
    logic       acc_en;
    logic [2:0] acc_step;
    logic       sq_clr;
    logic       sum_rd;
    logic       sum_wr;
    logic       mag;
    logic       max;
    logic       shl;
    logic       shr;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] comp;
    logic       out_load;
    logic       out_zero;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic a_ok;
    logic tri_ok;
    logic mmax_zero;
    logic mmax_hi;
    logic mmax_lo;
    logic out_busy;
  } sts_t;

  function automatic logic [COORD_W-1:0] coord_in(input logic [COORD_W-1:0] raw);
    logic [COORD_W-1:0] r;
    r = raw;
    for (int i = CIN_BITS; i < COORD_W; i++) begin
      r[i] = raw[CIN_BITS-1];
    end
    return r;
  endfunction

  function automatic logic idx_ok(input logic [IDX_BITS-1:0] i);
    return (int'(i) < VERTEX_COUNT);
  endfunction

endpackage

// File: design/vna_ctrl.sv
// Controller state machine sequencing writes, triangle updates and normalized reads.
module vna_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vna_pkg::sts_t sts_i,
  output vna_pkg::cmd_t cmd_o
);
  import vna_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DEC  = 15'b000000000000010,
    S_VRD  = 15'b000000000000100,
    S_DIFF = 15'b000000000001000,
    S_MUL  = 15'b000000000010000,
    S_SRD  = 15'b000000000100000,
    S_SWR  = 15'b000000001000000,
    S_RRD  = 15'b000000010000000,
    S_MAG  = 15'b000000100000000,
    S_MAX  = 15'b000001000000000,
    S_NORM = 15'b000010000000000,
    S_SQ   = 15'b000100000000000,
    S_SQRT = 15'b001000000000000,
    S_DIV  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  logic             zero_q, zero_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    zero_d  = zero_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        cnt_d  = '0;
        comp_d = '0;
        unique case (sts_i.op)
          OP_WRITE: begin
            cmd_o.vtx_wr = sts_i.a_ok;
            state_d      = S_IDLE;
          end
          OP_TRI: begin
            state_d = sts_i.tri_ok ? S_VRD : S_IDLE;
          end
          OP_READ: begin
            if (sts_i.a_ok) begin
              state_d = S_RRD;
            end else begin
              zero_d  = 1'b1;
              state_d = S_OUT;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_VRD: begin
        cmd_o.vtx_rd = 1'b1;
        cmd_o.corner = cnt_q[1:0];
        if (cnt_q[1:0] == CORNER_LAST) begin
          cnt_d   = '0;
          state_d = S_DIFF;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en   = (cnt_q < TRI_MUL_LAST);
        cmd_o.mul_step = cnt_q[2:0];
        cmd_o.acc_en   = (cnt_q != '0);
        cmd_o.acc_step = cnt_q[2:0] - 3'd1;
        if (cnt_q == TRI_MUL_LAST) begin
          cnt_d   = '0;
          comp_d  = '0;
          state_d = S_SRD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_SRD: begin
        cmd_o.sum_rd = 1'b1;
        cmd_o.corner = comp_q;
        state_d      = S_SWR;
      end
      S_SWR: begin
        cmd_o.sum_wr = 1'b1;
        if (comp_q == CORNER_LAST) begin
          state_d = S_IDLE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_SRD;
        end
      end
      S_RRD: begin
        cmd_o.sum_rd = 1'b1;
        state_d      = S_MAG;
      end
      S_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = S_MAX;
      end
      S_MAX: begin
        cmd_o.max = 1'b1;
        state_d   = S_NORM;
      end
      S_NORM: begin
        priority if (sts_i.mmax_zero) begin
          zero_d  = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.mmax_hi) begin
          cmd_o.shr = 1'b1;
        end else if (sts_i.mmax_lo) begin
          cmd_o.shl = 1'b1;
        end else begin
          cnt_d   = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.mul_sq   = 1'b1;
        cmd_o.mul_en   = (cnt_q < SQ_LAST);
        cmd_o.mul_step = cnt_q[2:0];
        cmd_o.acc_en   = (cnt_q != '0);
        cmd_o.sq_clr   = (cnt_q == '0);
        if (cnt_q == SQ_LAST) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_init = (cnt_q == '0);
        cmd_o.sqrt_step = (cnt_q != '0);
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          comp_d  = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DIV: begin
        cmd_o.comp      = comp_q;
        cmd_o.div_init  = (cnt_q == '0);
        cmd_o.div_step  = (cnt_q != '0) && (cnt_q != DIV_LAST);
        cmd_o.div_store = (cnt_q == DIV_LAST);
        if (cnt_q == DIV_LAST) begin
          cnt_d = '0;
          if (comp_q == CORNER_LAST) begin
            zero_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_zero = zero_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      zero_q  <= zero_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: design/vna_dp.sv
// Datapath: vertex and sum memories, shared multiplier, square root and divide units.
module vna_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vna_pkg::in_t  in_data_i,
  input  vna_pkg::cmd_t cmd_i,
  output vna_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vna_pkg::out_t out_data_o
);
  import vna_pkg::*;

  in_t                        item_q;
  logic [3*COORD_W-1:0]       vtx_mem [MEM_DEPTH];
  logic [3*COORD_W-1:0]       pos_q [3];
  logic signed [DIFF_W-1:0]   crd [3][3];
  logic signed [DIFF_W-1:0]   u_q [3];
  logic signed [DIFF_W-1:0]   v_q [3];
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   p_q;
  logic signed [NRM_W-1:0]    n_q [3];
  logic signed [NRM_W-1:0]    p_nrm;

  logic [3*SUM_W-1:0]         sum_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]       sum_vld_q;
  logic [3*SUM_W-1:0]         srd_q;
  logic                       srd_vld_q;
  logic [ADDR_W-1:0]          saddr_q;
  logic [3*SUM_W-1:0]         sum_new;
  logic [SUM_W-1:0]           s_base [3];
  logic [SUM_W-1:0]           s_mag [3];

  logic [SUM_W-1:0]           m_q [3];
  logic                       neg_q [3];
  logic [SUM_W-1:0]           mmax_q;
  logic [SQ_W-1:0]            sq_q;
  logic [SQ_W-1:0]            xs_q;
  logic [REM_W-1:0]           rem_q;
  logic [ROOT_W-1:0]          root_q;
  logic [REM_W+1:0]           sq_t, sq_trial;
  logic                       sq_ge;

  logic [NUM_W-1:0]           num;
  logic [ROOT_W-1:0]          r_q;
  logic [QUO_W-1:0]           nlo_q;
  logic [QUO_W-1:0]           quo_q;
  logic [ROOT_W:0]            dv_t;
  logic                       dv_ge;
  logic [OUT_W-1:0]           q16;
  logic [OUT_W-1:0]           res_q [3];

  logic                       out_valid_q;
  out_t                       out_q;

  logic [IDX_BITS-1:0]        idx_sel;
  logic [ADDR_W-1:0]          addr;

  always_comb begin
    unique case (cmd_i.corner)
      2'd0:    idx_sel = item_q.index_a;
      2'd1:    idx_sel = item_q.index_b;
      default: idx_sel = item_q.index_c;
    endcase
  end
  assign addr = idx_sel[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_wr) begin
      vtx_mem[item_q.index_a[ADDR_W-1:0]] <= {coord_in(item_q.pos_x),
                                              coord_in(item_q.pos_y),
                                              coord_in(item_q.pos_z)};
    end
    if (cmd_i.vtx_rd) begin
      pos_q[cmd_i.corner] <= vtx_mem[addr];
    end
  end

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) begin
        crd[s][k] = DIFF_W'($signed(pos_q[s][(2-k)*COORD_W +: COORD_W]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= crd[1][k] - crd[0][k];
        v_q[k] <= crd[2][k] - crd[0][k];
      end
    end
  end

  always_comb begin
    if (cmd_i.mul_sq) begin
      unique case (cmd_i.mul_step[1:0])
        2'd0:    mul_a = $signed({1'b0, m_q[0][MAG_W-1:0]});
        2'd1:    mul_a = $signed({1'b0, m_q[1][MAG_W-1:0]});
        default: mul_a = $signed({1'b0, m_q[2][MAG_W-1:0]});
      endcase
      mul_b = mul_a;
    end else begin
      unique case (cmd_i.mul_step)
        3'd0: begin mul_a = MUL_W'(v_q[1]); mul_b = MUL_W'(u_q[2]); end
        3'd1: begin mul_a = MUL_W'(v_q[2]); mul_b = MUL_W'(u_q[1]); end
        3'd2: begin mul_a = MUL_W'(v_q[2]); mul_b = MUL_W'(u_q[0]); end
        3'd3: begin mul_a = MUL_W'(v_q[0]); mul_b = MUL_W'(u_q[2]); end
        3'd4: begin mul_a = MUL_W'(v_q[0]); mul_b = MUL_W'(u_q[1]); end
        default: begin mul_a = MUL_W'(v_q[1]); mul_b = MUL_W'(u_q[0]); end
      endcase
    end
  end

  assign p_nrm = p_q[NRM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_en && !cmd_i.mul_sq) begin
      if (!cmd_i.acc_step[0]) begin
        n_q[cmd_i.acc_step[2:1]] <= p_nrm;
      end else begin
        n_q[cmd_i.acc_step[2:1]] <= n_q[cmd_i.acc_step[2:1]] - p_nrm;
      end
    end
    if (cmd_i.sq_clr) begin
      sq_q <= '0;
    end else if (cmd_i.acc_en && cmd_i.mul_sq) begin
      sq_q <= sq_q + $unsigned(p_q);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_base[k] = srd_vld_q ? srd_q[(2-k)*SUM_W +: SUM_W] : '0;
      s_mag[k]  = s_base[k][SUM_W-1] ? (~s_base[k] + SUM_W'(1)) : s_base[k];
      sum_new[(2-k)*SUM_W +: SUM_W] = s_base[k] + SUM_W'(n_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_rd) begin
      srd_q     <= sum_mem[addr];
      srd_vld_q <= sum_vld_q[addr];
      saddr_q   <= addr;
    end
    if (cmd_i.sum_wr) begin
      sum_mem[saddr_q] <= sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= '0;
    end else if (cmd_i.vtx_wr) begin
      sum_vld_q[item_q.index_a[ADDR_W-1:0]] <= 1'b0;
    end else if (cmd_i.sum_wr) begin
      sum_vld_q[saddr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag) begin
      for (int k = 0; k < 3; k++) begin
        m_q[k]   <= s_mag[k];
        neg_q[k] <= s_base[k][SUM_W-1];
      end
    end else if (cmd_i.max) begin
      priority if (m_q[0] >= m_q[1] && m_q[0] >= m_q[2]) begin
        mmax_q <= m_q[0];
      end else if (m_q[1] >= m_q[2]) begin
        mmax_q <= m_q[1];
      end else begin
        mmax_q <= m_q[2];
      end
    end else if (cmd_i.shr) begin
      for (int k = 0; k < 3; k++) begin
        m_q[k] <= m_q[k] >> 1;
      end
      mmax_q <= mmax_q >> 1;
    end else if (cmd_i.shl) begin
      for (int k = 0; k < 3; k++) begin
        m_q[k] <= m_q[k] << 1;
      end
      mmax_q <= mmax_q << 1;
    end
  end

  assign sq_t     = {rem_q, xs_q[SQ_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      xs_q   <= sq_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      xs_q   <= xs_q << 2;
      rem_q  <= sq_ge ? REM_W'(sq_t - sq_trial) : REM_W'(sq_t);
      root_q <= {root_q[ROOT_W-2:0], sq_ge};
    end
  end

  assign num   = NUM_W'({m_q[cmd_i.comp][MAG_W-1:0], FRAC_BITS'(0)}) + NUM_W'(root_q >> 1);
  assign dv_t  = {r_q, nlo_q[QUO_W-1]};
  assign dv_ge = (dv_t >= {1'b0, root_q});
  assign q16   = ({1'b0, quo_q} > Q_ONE) ? Q_ONE : {1'b0, quo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      r_q   <= ROOT_W'(num[NUM_W-1:QUO_W]);
      nlo_q <= num[QUO_W-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      r_q   <= dv_ge ? ROOT_W'(dv_t - {1'b0, root_q}) : dv_t[ROOT_W-1:0];
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[QUO_W-2:0], dv_ge};
    end
    if (cmd_i.div_store) begin
      res_q[cmd_i.comp] <= neg_q[cmd_i.comp] ? (~q16 + OUT_W'(1)) : q16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_zero) begin
        out_q <= '{norm_x: '0, norm_y: '0, norm_z: '0, zero_length: 1'b1};
      end else begin
        out_q <= '{norm_x: res_q[0], norm_y: res_q[1], norm_z: res_q[2],
                   zero_length: 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.op        = op_e'(item_q.operation);
  assign sts_o.a_ok      = idx_ok(item_q.index_a);
  assign sts_o.tri_ok    = idx_ok(item_q.index_a) && idx_ok(item_q.index_b) &&
                           idx_ok(item_q.index_c);
  assign sts_o.mmax_zero = (mmax_q == '0);
  assign sts_o.mmax_hi   = |mmax_q[SUM_W-1:MAG_W];
  assign sts_o.mmax_lo   = ~|mmax_q[SUM_W-1:MAG_W-1];
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled result");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sq_clr |-> (mmax_q[SUM_W-1:MAG_W] == '0) && mmax_q[MAG_W-1])
    else $error("squares started on unnormalized magnitudes");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> (root_q[ROOT_W-1:ROOT_W-2] != 2'b00))
    else $error("divide started with too small a length");

  a_valid_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.sum_wr && cmd_i.vtx_wr))
    else $error("vertex write and sum write in the same cycle");

endmodule

// File: design/vertex_normal_accumulator.sv
// Top level of the vertex normal accumulator: controller plus datapath.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one operation per
// transfer: write a vertex position (also clears its normal sum), add a
// triangle, or read a vertex normal. Only reads produce a result on the output
// channel (out_valid_o / out_stall_i / out_data_o) as a Q1.14 unit normal, or
// zero_length set with zero components.
// One item is processed at a time; in_stall_o is high while an item is busy.
// A triangle takes three vertex reads, six products on the shared multiplier
// and three read-modify-writes of the sum memory. A read takes a sum read,
// magnitudes, the largest magnitude, N one-bit normalizing shifts (N from 0
// to 23), three squares, a 25-step square root and three 15-step restoring
// divides. Out-of-range reads skip them; zero-length reads end at the maximum.
// The finished result sits in an output register; the next item is accepted
// while it waits, and only the next read result waits on out_stall_i.
// Reset (rst_ni, asynchronous, active low) clears all normal sums through
// per-vertex valid bits at once; vertex positions are undefined until written.
module vertex_normal_accumulator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vna_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vna_pkg::out_t out_data_o
);
  import vna_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vna_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
